// ===== rtl/tqh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the terrain height query block.
// No dependencies; every other file of the block but tqh_ram imports this package.
package tqh_pkg;

  // Height map geometry
  localparam int GRID_POINTS = 256;
  localparam int CELLS       = GRID_POINTS - 1;
  localparam int STORE_DEPTH = GRID_POINTS * GRID_POINTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int HEIGHT_W   = 16;
  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 24;
  localparam int GRID_IDX_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fixed-point arithmetic
  localparam int DIFF_W     = COORD_W + 1;          // world - origin
  localparam int POS_W      = DIFF_W + SCALE_W;     // Q.24 cell position
  localparam int POS_FRAC   = 24;
  localparam int CELL_W     = POS_W - POS_FRAC;
  localparam int FRAC_W     = 16;
  localparam int FRAC_ONE   = 65536;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int PROD_W     = HEIGHT_W + WEIGHT_W;
  localparam int ACC_W      = PROD_W + 1;

  // Back end sequencing
  localparam int N_CORNERS = 3;
  localparam int STEP_W    = 3;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 2'd0,
    CFG_ORIGIN_Z   = 2'd1,
    CFG_CELL_SCALE = 2'd2
  } tqh_cfg_idx_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } tqh_req_t;

  typedef struct packed {
    logic                        req_type;
    logic [GRID_IDX_W-1:0]       grid_x;
    logic [GRID_IDX_W-1:0]       grid_z;
    logic signed [HEIGHT_W-1:0]  height_in;
    logic signed [COORD_W-1:0]   world_x;
    logic signed [COORD_W-1:0]   world_z;
  } tqh_in_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_out;
    logic                       inside_res;
  } tqh_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_z;
    logic [SCALE_W-1:0]        cell_scale;
  } tqh_cfg_t;

  // One classified word handed from the front to the back.
  // addr is the load address, or the top-left corner of the cell of a query.
  typedef struct packed {
    tqh_req_t                   op;
    logic                       on_map;
    logic [ADDR_W-1:0]          addr;
    logic signed [HEIGHT_W-1:0] height;
    logic [FRAC_W-1:0]          fx;
    logic [FRAC_W-1:0]          fz;
  } tqh_entry_t;

endpackage

// ===== rtl/tqh_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port and one read port with registered read data.
// No dependencies.
module tqh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tqh_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
// Depends on tqh_pkg.
module tqh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tqh_pkg::tqh_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output tqh_pkg::tqh_entry_t head
);
  import tqh_pkg::*;

  tqh_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  function automatic logic [Q_PTR_W-1:0] wrap_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tqh_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request words, maps query positions to cells and fractions.
// Depends on tqh_pkg; feeds tqh_queue.
module tqh_front (
  input  logic                clk,
  input  logic                rst,
  input  tqh_pkg::tqh_cfg_t   cfg,
  input  logic                req_valid,
  output logic                req_stall,
  input  tqh_pkg::tqh_in_t    req_word,
  output logic                q_push,
  output tqh_pkg::tqh_entry_t q_data,
  input  logic                q_full
);
  import tqh_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SUB,
    F_MULX,
    F_MULZ,
    F_PUSH
  } front_state_t;

  front_state_t             state;
  tqh_in_t                  item;
  logic signed [DIFF_W-1:0] tx;
  logic signed [DIFF_W-1:0] tz;
  logic signed [POS_W-1:0]  px;
  logic signed [POS_W-1:0]  pz;

  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [SCALE_W:0]   scale_s;
  logic signed [POS_W:0]     mul_p;
  logic                      load_ok;
  logic [CELL_W-1:0]         cx;
  logic [CELL_W-1:0]         cz;
  logic                      in_map;

  // One multiplier, shared by the two axes
  assign scale_s = {1'b0, cfg.cell_scale};
  assign mul_a   = (state == F_MULX) ? tx : tz;
  assign mul_p   = mul_a * scale_s;

  assign load_ok = (int'(req_word.grid_x) < GRID_POINTS) &&
                   (int'(req_word.grid_z) < GRID_POINTS);

  assign req_stall = (state != F_IDLE);
  assign q_push    = (state == F_PUSH) && !q_full;

  // Floored cell index is the integer part; the sign bit marks negative cells
  assign cx     = px[POS_W-1:POS_FRAC];
  assign cz     = pz[POS_W-1:POS_FRAC];
  assign in_map = !cx[CELL_W-1] && !cz[CELL_W-1] &&
                  (cx < CELL_W'(CELLS)) && (cz < CELL_W'(CELLS));

  always_comb begin
    q_data        = '0;
    q_data.op     = tqh_req_t'(item.req_type);
    q_data.height = item.height_in;
    if (item.req_type == REQ_QUERY) begin
      q_data.on_map = in_map;
      q_data.addr   = ADDR_W'(ADDR_W'(cx) * ADDR_W'(GRID_POINTS) + ADDR_W'(cz));
      q_data.fx     = px[POS_FRAC-1:POS_FRAC-FRAC_W];
      q_data.fz     = pz[POS_FRAC-1:POS_FRAC-FRAC_W];
    end else begin
      q_data.addr   = ADDR_W'(ADDR_W'(item.grid_x) * ADDR_W'(GRID_POINTS) +
                              ADDR_W'(item.grid_z));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req_valid) begin
            item <= req_word;
            if (req_word.req_type == REQ_QUERY) begin
              state <= F_SUB;
            end else if (load_ok) begin
              state <= F_PUSH;
            end
          end
        end
        F_SUB: begin
          tx    <= DIFF_W'(item.world_x) - DIFF_W'(cfg.origin_x);
          tz    <= DIFF_W'(item.world_z) - DIFF_W'(cfg.origin_z);
          state <= F_MULX;
        end
        F_MULX: begin
          px    <= mul_p[POS_W-1:0];
          state <= F_MULZ;
        end
        F_MULZ: begin
          pz    <= mul_p[POS_W-1:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tqh_back.sv =====
`timescale 1ns / 1ps
// Back end: owns the height memory, performs loads and triangle interpolation.
// Depends on tqh_pkg and tqh_ram; drains tqh_queue.
module tqh_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tqh_pkg::tqh_entry_t q_head,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output tqh_pkg::tqh_out_t   res_word
);
  import tqh_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_OUT
  } back_state_t;

  back_state_t              state;
  logic [STEP_W-1:0]        step;
  logic [ADDR_W-1:0]        addr_sh [N_CORNERS];
  logic [WEIGHT_W-1:0]      w_sh    [N_CORNERS];
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic                     out_free;
  logic                     res_load;
  logic                     ram_we;
  logic                     ram_re;
  logic [HEIGHT_W-1:0]      ram_rdata;
  logic [WEIGHT_W-1:0]      fsum;
  logic                     lower;
  logic [ADDR_W-1:0]        tri_addr [N_CORNERS];
  logic [WEIGHT_W-1:0]      tri_w    [N_CORNERS];
  logic signed [ACC_W-1:0]  rsum;

  assign out_free = !res_valid || !res_stall;
  assign ram_we   = (state == B_IDLE) && q_valid && (q_head.op == REQ_LOAD);
  assign ram_re   = (state == B_CALC) && (step < STEP_W'(N_CORNERS));
  assign q_pop    = (state == B_IDLE) && q_valid &&
                    ((q_head.op == REQ_LOAD) || q_head.on_map || out_free);
  // A new result enters the output register this cycle
  assign res_load = ((state == B_IDLE) && q_valid && (q_head.op == REQ_QUERY) &&
                     !q_head.on_map && out_free) ||
                    ((state == B_OUT) && out_free);

  tqh_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr),
    .wdata (q_head.height),
    .re    (ram_re),
    .raddr (addr_sh[0]),
    .rdata (ram_rdata)
  );

  // Pick the triangle and its three corners with their weights
  always_comb begin
    fsum  = {1'b0, q_head.fx} + {1'b0, q_head.fz};
    lower = (fsum <= WEIGHT_W'(FRAC_ONE));
    if (lower) begin
      tri_addr[0] = q_head.addr;
      tri_w[0]    = WEIGHT_W'(FRAC_ONE) - fsum;
      tri_addr[1] = q_head.addr + ADDR_W'(GRID_POINTS);
      tri_w[1]    = {1'b0, q_head.fx};
      tri_addr[2] = q_head.addr + ADDR_W'(1);
      tri_w[2]    = {1'b0, q_head.fz};
    end else begin
      tri_addr[0] = q_head.addr + ADDR_W'(GRID_POINTS);
      tri_w[0]    = WEIGHT_W'(FRAC_ONE) - {1'b0, q_head.fz};
      tri_addr[1] = q_head.addr + ADDR_W'(GRID_POINTS) + ADDR_W'(1);
      tri_w[1]    = fsum - WEIGHT_W'(FRAC_ONE);
      tri_addr[2] = q_head.addr + ADDR_W'(1);
      tri_w[2]    = WEIGHT_W'(FRAC_ONE) - {1'b0, q_head.fx};
    end
  end

  // Round half up: add half an LSB, then floor
  assign rsum = acc + ACC_W'(FRAC_ONE / 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid && (q_head.op == REQ_QUERY)) begin
            if (!q_head.on_map) begin
              if (out_free) begin
                res_word.height_out <= '0;
                res_word.inside_res <= 1'b0;
              end
            end else begin
              for (int i = 0; i < N_CORNERS; i++) begin
                addr_sh[i] <= tri_addr[i];
                w_sh[i]    <= tri_w[i];
              end
              acc   <= '0;
              step  <= '0;
              state <= B_CALC;
            end
          end
        end
        B_CALC: begin
          // Read corner k, multiply corner k-1, accumulate corner k-2
          step <= step + STEP_W'(1);
          for (int i = 0; i < N_CORNERS - 1; i++) begin
            addr_sh[i] <= addr_sh[i+1];
          end
          if ((step >= STEP_W'(1)) && (step <= STEP_W'(N_CORNERS))) begin
            prod <= $signed(ram_rdata) * $signed({1'b0, w_sh[0]});
            for (int i = 0; i < N_CORNERS - 1; i++) begin
              w_sh[i] <= w_sh[i+1];
            end
          end
          if (step >= STEP_W'(2)) begin
            acc <= acc + ACC_W'(prod);
          end
          if (step == STEP_W'(N_CORNERS + 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            res_word.height_out <= rsum[FRAC_W+HEIGHT_W-1:FRAC_W];
            res_word.inside_res <= 1'b1;
            state               <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/terrain_height_query.sv =====
`timescale 1ns / 1ps
// Top level of the terrain height query block: configuration registers and wiring.
// Depends on tqh_pkg, tqh_front, tqh_queue and tqh_back.
//
// The block keeps a GRID_POINTS x GRID_POINTS map of Q8.8 heights and answers
// height queries at Q24.8 world positions. A load word writes one height and
// gives no result; a load with an index beyond the map is dropped. A query word
// gives exactly one result: the height interpolated over the triangle of the
// cell that holds the point, or height 0 with inside_res low when the point
// falls outside the map's cells. Words are served in order, so a query always
// sees every load accepted before it. The height memory holds no defined value
// after reset, and a query may only touch entries that were loaded; there is
// no clearing pass. The front accepts a word; for a query it then subtracts
// the origin, forms two products through one shared 33x25 multiplier and
// classifies the point; then it pushes the word, a load straight after accept.
// The back reads the three corners of a query inside the map from the single
// read port of the height memory, overlapped with a multiply-accumulate, and
// serves an outside query or a load straight from idle. Neither end takes a
// new word before it is done with the last; a four-word queue parts front
// and back, and the result register lets a load or an on-map query enter
// while a result waits. Write configuration only while no word is in flight.
module terrain_height_query (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  tqh_pkg::tqh_in_t                     req_word,
  // result channel
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output tqh_pkg::tqh_out_t                    res_word,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [tqh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tqh_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tqh_pkg::*;

  tqh_cfg_t   cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  tqh_entry_t q_data;
  tqh_entry_t q_head;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_z   <= '0;
      cfg.cell_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:   cfg.origin_x   <= cfg_data;
        CFG_ORIGIN_Z:   cfg.origin_z   <= cfg_data;
        CFG_CELL_SCALE: cfg.cell_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify each word
  tqh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  // Hold classified words until the back is free
  tqh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back: write heights, interpolate, drive the result register
  tqh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("queue overflow");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue underflow");

  // An accepted word makes the front busy, so it never takes words back to back
  assert property (@(posedge clk) disable iff (rst)
                   (req_valid && !req_stall) |=> req_stall)
    else $error("front accepted back-to-back words");

  // An outside result carries height zero
  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && !res_word.inside_res) |-> (res_word.height_out == '0))
    else $error("outside result with nonzero height");

endmodule

// ===== tb/sv/terrain_height_query_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of terrain_height_query: random and directed load and query words
// with an in-bench height predictor. Depends on tqh_pkg and the terrain_height_query RTL.
module terrain_height_query_test;
  import tqh_pkg::*;

  // Cycles to let pass once no result is due, so a trailing load can land.
  localparam int DRAIN_CYCLES = 32;
  // Print detail for this many bad results, count the rest.
  localparam int REPORT_MAX   = 10;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  tqh_in_t               req_word  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  tqh_out_t              res_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  terrain_height_query u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the block's state: configuration, height map, and which
  // entries were loaded. A query is only sent once all four corners of its
  // cell hold a loaded height, so the block never reads an undefined entry.
  logic signed [COORD_W-1:0]  org_x = '0;
  logic signed [COORD_W-1:0]  org_z = '0;
  logic [SCALE_W-1:0]         scale = SCALE_RESET;
  logic signed [HEIGHT_W-1:0] map_mem [STORE_DEPTH];
  bit                         map_set [STORE_DEPTH];

  // Heights the block still owes, oldest first.
  tqh_out_t    height_due [$];
  tqh_out_t    want;
  int unsigned miss_count  = 0;
  int unsigned words_sent  = 0;
  // Percent of cycles the sender idles and the receiver stalls.
  int unsigned send_gap_pct = 0;
  int unsigned res_hold_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("terrain_height_query: mismatch");
    $finish;
  end

  // Receiver: decide the stall for the next edge on every falling edge.
  always @(negedge clk) res_stall <= ($urandom_range(99) < res_hold_pct);

  // ---------------------------------------------------------------------------
  // Height predictor
  // ---------------------------------------------------------------------------

  // Map a world coordinate to a floored cell index and a 16-bit fraction.
  // The product carries 24 fraction bits; an arithmetic shift floors it.
  function automatic void split_coord(input logic signed [COORD_W-1:0] world,
                                      input logic signed [COORD_W-1:0] origin,
                                      output longint cell_idx, output longint frac);
    longint diff;
    longint pos;
    diff     = longint'(world) - longint'(origin);
    pos      = diff * longint'(scale);
    cell_idx = pos >>> POS_FRAC;
    frac     = (pos >>> 8) & 64'hFFFF;
  endfunction

  // Height under one query word, using the map as it stands right now.
  function automatic tqh_out_t predict_height(input tqh_in_t w);
    longint   cx, cz, fx, fz;
    longint   tl, tr, bl, br, acc;
    tqh_out_t r;
    r = '0;
    split_coord(w.world_x, org_x, cx, fx);
    split_coord(w.world_z, org_z, cz, fz);
    if (cx < 0 || cz < 0 || cx >= CELLS || cz >= CELLS) return r;
    tl = map_mem[cx * GRID_POINTS + cz];
    tr = map_mem[(cx + 1) * GRID_POINTS + cz];
    bl = map_mem[cx * GRID_POINTS + cz + 1];
    br = map_mem[(cx + 1) * GRID_POINTS + cz + 1];
    // Lower triangle when fx + fz <= 1 (the diagonal belongs to it).
    if (fx + fz <= FRAC_ONE)
      acc = tl * (FRAC_ONE - fx - fz) + tr * fx + bl * fz;
    else
      acc = tr * (FRAC_ONE - fz) + br * (fx + fz - FRAC_ONE) + bl * (FRAC_ONE - fx);
    // Drop 16 fraction bits, rounding half toward plus infinity.
    acc = (acc + 32768) >>> FRAC_W;
    r.height_out = acc[HEIGHT_W-1:0];
    r.inside_res = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random content in every field; callers overwrite the ones that matter.
  function automatic tqh_in_t scramble();
    tqh_in_t w;
    w.req_type  = 1'($urandom_range(1));
    w.grid_x    = GRID_IDX_W'($urandom);
    w.grid_z    = GRID_IDX_W'($urandom);
    w.height_in = HEIGHT_W'($urandom);
    w.world_x   = $urandom;
    w.world_z   = $urandom;
    return w;
  endfunction

  // Offer one word, hold it until accepted, then update the prediction.
  // Valid is only raised or dropped on a falling edge and at most once there.
  task automatic send_word(input tqh_in_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
      req_word  <= scramble();
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall !== 1'b0);
    words_sent++;
    if (w.req_type == REQ_QUERY) begin
      height_due.push_back(predict_height(w));
    end else begin
      // Every 8-bit index lies on a 256-point map, so no load is dropped here.
      map_mem[int'(w.grid_x) * GRID_POINTS + int'(w.grid_z)] = w.height_in;
      map_set[int'(w.grid_x) * GRID_POINTS + int'(w.grid_z)] = 1'b1;
    end
  endtask

  task automatic send_load(input logic [GRID_IDX_W-1:0] x, input logic [GRID_IDX_W-1:0] z,
                           input logic signed [HEIGHT_W-1:0] h);
    tqh_in_t w;
    w           = scramble();
    w.req_type  = REQ_LOAD;
    w.grid_x    = x;
    w.grid_z    = z;
    w.height_in = h;
    send_word(w);
  endtask

  // Load any missing corner of the target cell first, then send the query.
  task automatic send_query(input logic signed [COORD_W-1:0] wx,
                            input logic signed [COORD_W-1:0] wz);
    tqh_in_t w;
    longint  cx, cz, f;
    split_coord(wx, org_x, cx, f);
    split_coord(wz, org_z, cz, f);
    if (cx >= 0 && cz >= 0 && cx < CELLS && cz < CELLS) begin
      for (int dx = 0; dx < 2; dx++)
        for (int dz = 0; dz < 2; dz++)
          if (!map_set[(cx + dx) * GRID_POINTS + cz + dz])
            send_load(GRID_IDX_W'(cx + dx), GRID_IDX_W'(cz + dz), HEIGHT_W'($urandom));
    end
    w          = scramble();
    w.req_type = REQ_QUERY;
    w.world_x  = wx;
    w.world_z  = wz;
    send_word(w);
  endtask

  // Pick a world coordinate that mostly lands on the map under the current
  // origin and scale, with some weight on the first and last cell edges.
  function automatic logic signed [COORD_W-1:0] aim_coord(input logic signed [COORD_W-1:0] origin);
    longint      span, t;
    int unsigned pick;
    if (scale == '0) return $urandom;
    span = ((longint'(CELLS) <<< POS_FRAC) - 1) / longint'(scale);
    pick = $urandom_range(99);
    if (pick < 5)
      t = -1 - longint'($urandom_range(3));
    else if (pick < 10)
      t = span + longint'($urandom_range(3));
    else if (pick < 13)
      t = 0;
    else
      t = longint'($urandom_range(span[31:0]));
    return COORD_W'(longint'(origin) + t);
  endfunction

  // Mixed traffic: random loads, queries aimed at the map, and wild queries.
  task automatic random_words(input int unsigned count);
    int unsigned stop;
    int unsigned pick;
    stop = words_sent + count;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 20)
        send_load(GRID_IDX_W'($urandom), GRID_IDX_W'($urandom), HEIGHT_W'($urandom));
      else if (pick < 88)
        send_query(aim_coord(org_x), aim_coord(org_z));
      else
        send_query($urandom, $urandom);
    end
  endtask

  // Drop valid and hold off until the block has answered everything.
  task automatic wait_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (height_due.size() != 0) @(posedge clk);
  endtask

  // Full quiet point: no result due and no load left in flight.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input tqh_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:   org_x = val;
      CFG_ORIGIN_Z:   org_z = val;
      CFG_CELL_SCALE: scale = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: one world unit per cell, so the cell is world >>> 8
  // and the fraction is the low byte. Cover both triangles, the diagonal,
  // rounding of exact halves, the last cell, and points just off the map.
  task automatic test_directed();
    send_gap_pct = 0;
    res_hold_pct = 0;
    send_load(0, 0, 16'sh7FFF);
    send_load(1, 0, 16'sh8000);
    send_load(0, 1, 16'sh8000);
    send_load(1, 1, 16'sh1234);
    send_query(0, 0);
    send_query(32'h80, 32'h80);           // on the diagonal: lower triangle
    send_query(32'h80, 32'h81);           // just past it: upper triangle
    send_query(32'hFF, 32'hFF);
    send_query(32'hFF, 32'h00);
    // Cells 2 and 3 along x: exact halves of -1 and of +1.
    send_load(2, 0, 0);
    send_load(3, 0, -1);
    send_load(2, 1, 0);
    send_load(3, 1, 0);
    send_load(4, 0, 0);
    send_load(4, 1, 1);
    send_query(2 * 256 + 32'h80, 0);      // -0.5 rounds up to 0
    send_query(3 * 256 + 32'hC0, 32'hC0); // +0.5 rounds up to 1
    send_query(254 * 256 + 32'hFF, 254 * 256 + 32'hFF);
    send_query(255 * 256, 0);
    send_query(-1, 0);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // Origins at the bottom of their range, then origin x at the top; scale at both ends of its range.
  task automatic test_extreme_origins();
    settle();
    set_reg(CFG_ORIGIN_X, 32'h8000_0000);
    set_reg(CFG_ORIGIN_Z, 32'h8000_0000);
    set_reg(CFG_CELL_SCALE, 32'd1);
    send_gap_pct = 56;
    res_hold_pct = 0;
    random_words(120);
    settle();
    set_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
    set_reg(CFG_ORIGIN_Z, int'($urandom_range(8192)) - 4096);
    set_reg(CFG_CELL_SCALE, 32'h00FF_FFFF);
    random_words(40);
  endtask

  // Finest grid with a busy receiver; junk in the unused top byte of the write.
  task automatic test_fine_scale();
    settle();
    set_reg(CFG_ORIGIN_X, int'($urandom_range(131072)) - 65536);
    set_reg(CFG_ORIGIN_Z, int'($urandom_range(131072)) - 65536);
    set_reg(CFG_CELL_SCALE, 32'hA5FF_FFFF);
    send_gap_pct = 0;
    res_hold_pct = 56;
    random_words(150);
  endtask

  // A zero scale folds every point onto the top-left corner of cell (0,0).
  task automatic test_zero_scale();
    settle();
    set_reg(CFG_CELL_SCALE, 32'd0);
    send_gap_pct = 14;
    res_hold_pct = 14;
    repeat (12) send_query($urandom, $urandom);
  endtask

  // Several random settings; pause once per setting until all results are in.
  task automatic test_random_config();
    for (int round = 0; round < 3; round++) begin
      settle();
      case (round)
        0: begin
          set_reg(CFG_ORIGIN_X, $urandom);
          set_reg(CFG_ORIGIN_Z, $urandom);
          set_reg(CFG_CELL_SCALE, $urandom_range(24'hFF_FFFF, 1));
        end
        1: begin
          set_reg(CFG_ORIGIN_X, int'($urandom_range(1 << 21)) - (1 << 20));
          set_reg(CFG_ORIGIN_Z, int'($urandom_range(1 << 21)) - (1 << 20));
          set_reg(CFG_CELL_SCALE, $urandom_range(1 << 20, 256));
        end
        default: begin
          set_reg(CFG_ORIGIN_X, int'($urandom_range(1 << 13)) - (1 << 12));
          set_reg(CFG_ORIGIN_Z, int'($urandom_range(1 << 13)) - (1 << 12));
          set_reg(CFG_CELL_SCALE, $urandom_range(1 << 18, 1 << 14));
        end
      endcase
      send_gap_pct = 14;
      res_hold_pct = 14;
      random_words(50);
      wait_results();
      random_words(50);
    end
  endtask

  // Back to the reset-style setting, with no sender gaps and no receiver stalls.
  task automatic test_streaming();
    settle();
    set_reg(CFG_ORIGIN_X, 32'd0);
    set_reg(CFG_ORIGIN_Z, 32'd0);
    set_reg(CFG_CELL_SCALE, 32'd65536);
    send_gap_pct = 0;
    res_hold_pct = 0;
    random_words(150);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      if (height_due.size() == 0) begin
        miss_count++;
        if (miss_count <= REPORT_MAX)
          $display("[%0t] result with none due: height %0d inside %0b",
                   $time, res_word.height_out, res_word.inside_res);
      end else begin
        want = height_due.pop_front();
        if (res_word.height_out !== want.height_out ||
            res_word.inside_res !== want.inside_res) begin
          miss_count++;
          if (miss_count <= REPORT_MAX)
            $display("[%0t] bad result: expected height %0d inside %0b, got height %0d inside %0b",
                     $time, want.height_out, want.inside_res,
                     res_word.height_out, res_word.inside_res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_extreme_origins();
    test_fine_scale();
    test_zero_scale();
    test_random_config();
    test_streaming();
    settle();
    if (miss_count == 0 && height_due.size() == 0)
      $display("terrain_height_query: match");
    else
      $display("terrain_height_query: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tqh_pkg.sv
rtl/tqh_ram.sv
rtl/tqh_queue.sv
rtl/tqh_front.sv
rtl/tqh_back.sv
rtl/terrain_height_query.sv
tb/sv/terrain_height_query_test.sv
